[hdl/segment_overlap_checker_macros.svh]
// ----------------------------------------------------------------------------
// segment_overlap_checker assertion macros
// shared property wrappers for the range table checks
// ----------------------------------------------------------------------------
`ifndef SEGMENT_OVERLAP_CHECKER_MACROS_SVH
`define SEGMENT_OVERLAP_CHECKER_MACROS_SVH

// check that is switched off while reset is high
`define SOC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check that also holds during reset
`define SOC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[hdl/soc_pkg.sv]
// ----------------------------------------------------------------------------
// soc_pkg
// sizes, status codes and shared structs of the segment overlap checker
// ----------------------------------------------------------------------------
`default_nettype none

package soc_pkg;

   // table geometry
   localparam int SEGMENTS = 64;
   localparam int IDX_W    = $clog2(SEGMENTS);
   localparam int ADDR_W   = 48;
   localparam int SUM_W    = ADDR_W + 1;
   localparam int COUNT_W  = 7;
   localparam int STAT_W   = 3;

   localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(SEGMENTS - 1);
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // request actions
   localparam logic ACT_REGISTER   = 1'b0;
   localparam logic ACT_UNREGISTER = 1'b1;

   // result status codes
   typedef logic [STAT_W-1:0] status_type;
   localparam status_type STAT_OK       = 3'd0;
   localparam status_type STAT_NULL     = 3'd1;
   localparam status_type STAT_OVERLAP  = 3'd2;
   localparam status_type STAT_NOTFOUND = 3'd3;
   localparam status_type STAT_FULL     = 3'd4;

   typedef logic [ADDR_W-1:0] addr_type;

   // control from the sequencer to the range table
   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_idx;
      logic             wr_en;
      logic [IDX_W-1:0] wr_idx;
      addr_type         wr_base;
      addr_type         wr_size;
      logic             clr_en;
      logic [IDX_W-1:0] clr_idx;
   } tbl_ctl_type;

   // one entry as read back from the table
   typedef struct packed {
      logic     valid;
      addr_type base;
      addr_type size;
   } entry_type;

   // verdict of the shared compare unit
   typedef struct packed {
      logic clash;
      logic lower;
   } cmp_res_type;

endpackage

`default_nettype wire

[hdl/soc_if.sv]
// ----------------------------------------------------------------------------
// soc_if
// valid/ready channels for requests and results of the overlap checker
// ----------------------------------------------------------------------------
`default_nettype none

// request channel
interface soc_req_if
   import soc_pkg::*;
;
   logic     valid;
   logic     ready;
   logic     action;
   addr_type range_base;
   addr_type range_size;

   modport source (output valid, action, range_base, range_size, input ready);
   modport sink   (input valid, action, range_base, range_size, output ready);
endinterface

// result channel
interface soc_rsp_if
   import soc_pkg::*;
;
   logic               valid;
   logic               ready;
   status_type         status;
   addr_type           clash_base;
   addr_type           clash_size;
   logic [COUNT_W-1:0] removed_count;

   modport source (output valid, status, clash_base, clash_size, removed_count,
                   input ready);
   modport sink   (input valid, status, clash_base, clash_size, removed_count,
                   output ready);
endinterface

`default_nettype wire

[hdl/segment_overlap_checker.sv]
// ----------------------------------------------------------------------------
// segment_overlap_checker
// table of active address ranges with clash check, store and removal
// ----------------------------------------------------------------------------
// A request is accepted only while the block is idle. The scan reads one table
// entry per cycle through the single memory read port and judges it in the
// shared compare unit. Once the last entry is judged the block moves to its
// done state, loads the result into the output register and goes back to idle,
// where the next request can be accepted. A request with a null base skips the
// scan: it goes straight to the done state, from which its result is loaded.
// A new request is accepted even while the previous result still waits in the
// output register, but once its own scan is over it holds its result back, and
// the input stays closed, until that register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_overlap_checker
   import soc_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   soc_req_if.sink    req,
   soc_rsp_if.source  rsp
);

`include "segment_overlap_checker_macros.svh"

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type          state_ff, state_in;

   // request held for the scan
   logic               act_ff, act_in;
   addr_type           base_ff, base_in;
   addr_type           size_ff, size_in;
   logic               null_ff, null_in;

   // read issue and compare stage
   logic               issue_ff, issue_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;

   // scan findings
   logic               hit_ff, hit_in;
   addr_type           hit_base_ff, hit_base_in;
   addr_type           hit_size_ff, hit_size_in;
   logic               free_ff, free_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic [COUNT_W-1:0] removed_ff, removed_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   addr_type           rsp_base_ff, rsp_base_in;
   addr_type           rsp_size_ff, rsp_size_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   tbl_ctl_type        tbl_ctl;
   entry_type          ent;
   cmp_res_type        cmp;
   logic               accept;
   logic               load_rsp;
   logic               ent_clash;

   soc_table u_table (
      .clock    (clock),
      .reset    (reset),
      .ctl      (tbl_ctl),
      .rd_entry (ent)
   );

   soc_cmp u_cmp (
      .req_base  (base_ff),
      .req_size  (size_ff),
      .ent_base  (ent.base),
      .ent_size  (ent.size),
      .best_base (hit_base_ff),
      .res       (cmp)
   );

   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;
   assign load_rsp  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp.ready);
   assign ent_clash = cmp_vld_ff && ent.valid && cmp.clash;

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = (req.range_base == '0) ? S_DONE : S_SCAN;
            end
         end
         S_SCAN: begin
            if (cmp_vld_ff && (cmp_idx_ff == LAST_IDX)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // request capture and read issue
   always_comb begin
      act_in     = act_ff;
      base_in    = base_ff;
      size_in    = size_ff;
      null_in    = null_ff;
      issue_in   = issue_ff;
      idx_in     = idx_ff;
      cmp_vld_in = issue_ff;
      cmp_idx_in = idx_ff;
      if (accept) begin
         act_in   = req.action;
         base_in  = req.range_base;
         size_in  = req.range_size;
         null_in  = (req.range_base == '0);
         issue_in = (req.range_base != '0);
         idx_in   = '0;
      end else if (issue_ff) begin
         idx_in = idx_ff + IDX_W'(1);
         if (idx_ff == LAST_IDX) begin
            issue_in = 1'b0;
         end
      end
   end

   // scan findings: lowest clashing base, first free entry, removals
   always_comb begin
      hit_in      = hit_ff;
      hit_base_in = hit_base_ff;
      hit_size_in = hit_size_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      removed_in  = removed_ff;
      if (accept) begin
         hit_in     = 1'b0;
         free_in    = 1'b0;
         removed_in = '0;
      end else if (cmp_vld_ff) begin
         if (!ent.valid && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = cmp_idx_ff;
         end
         if (ent_clash && (!hit_ff || cmp.lower)) begin
            hit_in      = 1'b1;
            hit_base_in = ent.base;
            hit_size_in = ent.size;
         end
         if (ent_clash && (removed_ff != COUNT_MAX)) begin
            removed_in = removed_ff + COUNT_W'(1);
         end
      end
   end

   // table control
   always_comb begin
      tbl_ctl         = '0;
      tbl_ctl.rd_en   = issue_ff;
      tbl_ctl.rd_idx  = idx_ff;
      tbl_ctl.clr_en  = ent_clash && (act_ff == ACT_UNREGISTER);
      tbl_ctl.clr_idx = cmp_idx_ff;
      tbl_ctl.wr_en   = load_rsp && !null_ff && (act_ff == ACT_REGISTER) &&
                        !hit_ff && free_ff;
      tbl_ctl.wr_idx  = free_idx_ff;
      tbl_ctl.wr_base = base_ff;
      tbl_ctl.wr_size = size_ff;
   end

   // result build
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_base_in   = rsp_base_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_count_in  = rsp_count_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_base_in  = '0;
         rsp_size_in  = '0;
         rsp_count_in = '0;
         priority if (null_ff) begin
            rsp_status_in = STAT_NULL;
         end else if (act_ff == ACT_UNREGISTER) begin
            rsp_count_in  = removed_ff;
            rsp_status_in = (removed_ff == '0) ? STAT_NOTFOUND : STAT_OK;
         end else if (hit_ff) begin
            rsp_status_in = STAT_OVERLAP;
            rsp_base_in   = hit_base_ff;
            rsp_size_in   = hit_size_ff;
         end else if (!free_ff) begin
            rsp_status_in = STAT_FULL;
         end else begin
            rsp_status_in = STAT_OK;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issue_ff     <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      base_ff       <= base_in;
      size_ff       <= size_in;
      null_ff       <= null_in;
      idx_ff        <= idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      hit_ff        <= hit_in;
      hit_base_ff   <= hit_base_in;
      hit_size_ff   <= hit_size_in;
      free_ff       <= free_in;
      free_idx_ff   <= free_idx_in;
      removed_ff    <= removed_in;
      rsp_status_ff <= rsp_status_in;
      rsp_base_ff   <= rsp_base_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = rsp_status_ff;
   assign rsp.clash_base    = rsp_base_ff;
   assign rsp.clash_size    = rsp_size_ff;
   assign rsp.removed_count = rsp_count_ff;

   // checks
   `SOC_ASSERT(a_cmp_in_scan, cmp_vld_ff |-> (state_ff == S_SCAN), "compare outside scan")
   `SOC_ASSERT(a_rsp_from_done, $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE), "result not from done")
   `SOC_ASSERT(a_count_only_ok, (rsp_valid_ff && (rsp_count_ff != '0)) |-> (rsp_status_ff == STAT_OK), "count on bad status")
   `SOC_ASSERT_ALWAYS(a_no_wr_clr, tbl_ctl.wr_en |-> !tbl_ctl.clr_en, "store and removal together")

endmodule

`default_nettype wire

[hdl/soc_table.sv]
// ----------------------------------------------------------------------------
// soc_table
// range storage: base and size memories with one read and one write port,
// valid bits in flip-flops
// ----------------------------------------------------------------------------
`default_nettype none

module soc_table
   import soc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire tbl_ctl_type ctl,
   output entry_type        rd_entry
);

   addr_type            base_mem [SEGMENTS];
   addr_type            size_mem [SEGMENTS];
   logic [SEGMENTS-1:0] valid_ff;
   logic [SEGMENTS-1:0] valid_in;
   logic                rd_valid_ff;
   addr_type            rd_base_ff;
   addr_type            rd_size_ff;

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         base_mem[ctl.wr_idx] <= ctl.wr_base;
         size_mem[ctl.wr_idx] <= ctl.wr_size;
      end
      if (ctl.rd_en) begin
         rd_base_ff <= base_mem[ctl.rd_idx];
         rd_size_ff <= size_mem[ctl.rd_idx];
      end
   end

   // valid bits: set on store, cleared on removal
   always_comb begin
      valid_in = valid_ff;
      if (ctl.clr_en) begin
         valid_in[ctl.clr_idx] = 1'b0;
      end
      if (ctl.wr_en) begin
         valid_in[ctl.wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (ctl.rd_en) begin
            rd_valid_ff <= valid_ff[ctl.rd_idx];
         end
      end
   end

   assign rd_entry = '{valid: rd_valid_ff, base: rd_base_ff, size: rd_size_ff};

endmodule

`default_nettype wire

[hdl/soc_cmp.sv]
// ----------------------------------------------------------------------------
// soc_cmp
// shared compare unit: range clash test and lowest-base selection
// ----------------------------------------------------------------------------
`default_nettype none

module soc_cmp
   import soc_pkg::*;
(
   input  wire addr_type    req_base,
   input  wire addr_type    req_size,
   input  wire addr_type    ent_base,
   input  wire addr_type    ent_size,
   input  wire addr_type    best_base,
   output cmp_res_type      res
);

   logic [SUM_W-1:0] req_end;
   logic [SUM_W-1:0] ent_end;

   // end addresses at one extra bit so they never wrap
   assign req_end = {1'b0, req_base} + {1'b0, req_size};
   assign ent_end = {1'b0, ent_base} + {1'b0, ent_size};

   // ranges clash unless one ends at or before the other begins
   assign res.clash = (req_end > {1'b0, ent_base}) && (ent_end > {1'b0, req_base});
   assign res.lower = ent_base < best_base;

endmodule

`default_nettype wire
